/* rtl/hms_pkg.sv */
// ----------------------------------------------------------------------------
// hms_pkg
// Shared widths, command codes, mode codes and reset values of the heater
// mode sequencer.
// ----------------------------------------------------------------------------
package hms_pkg;

    // Stream widths, the data and config widths padded to whole bytes
    localparam int S_TDATA_W = 112;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;
    localparam int CFG_W     = 8;

    // Field widths
    localparam int TEMP_W  = 16;
    localparam int STAMP_W = 32;
    localparam int DUR_W   = 23;

    // Interpolation works one bit per cycle over the span magnitude
    localparam int STEP_N = TEMP_W;
    localparam int CNT_W  = $clog2(STEP_N);
    localparam int ACC_W  = STAMP_W + STEP_N;

    localparam logic [STAMP_W-1:0] MS_PER_S      = 32'd1000;
    localparam logic [CFG_W-1:0]   HOLD_BAND_RST = 8'd16;

    // Command codes carried in s_tuser
    localparam logic [S_TUSER_W-1:0] CMD_TICK        = 3'd0;
    localparam logic [S_TUSER_W-1:0] CMD_START_OFF   = 3'd1;
    localparam logic [S_TUSER_W-1:0] CMD_START_RAMP  = 3'd2;
    localparam logic [S_TUSER_W-1:0] CMD_START_HOLD  = 3'd3;
    localparam logic [S_TUSER_W-1:0] CMD_START_TIMER = 3'd4;

    // Heater modes
    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_RAMP  = 2'd1,
        MODE_HOLD  = 2'd2,
        MODE_TIMER = 2'd3
    } mode_t;

endpackage

/* rtl/heater_mode_sequencer.sv */
// ----------------------------------------------------------------------------
// heater_mode_sequencer
// Steps a plate heater through off, ramp, hold and timer modes.
//
// Channels: commands enter on s_tvalid/s_tready/s_tdata/s_tuser, one result
// per command leaves on m_tvalid/m_tready/m_tdata. hold_band is written
// through cfg_wen/cfg_wdata; the user must write it only while the block
// is idle, which the block itself does not enforce.
// Flow: a start command or a tick outside an active ramp goes from the
// transfer through the emit state into the output register. A ramp tick
// first runs a bit-serial multiply and a restoring divide on one 48-bit
// accumulator, then goes through the emit state.
// Commands: one at a time; the next is taken once the current result has
// been moved into the output register.
// Reset: off mode, heater stopped, setpoint zero, hold_band 16, no result.
// Stall: the output register holds a finished result until m_tready; one
// more command may be taken and worked on meanwhile, and its result waits
// in the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module heater_mode_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    // now_ms[31:0], measured_temp[47:32], heater_fault[48], start_temp[64:49],
    // end_temp[80:65], duration_s[103:81], use_temp[104], zero pad above
    input  logic [hms_pkg::S_TDATA_W-1:0]  s_tdata,
    // command[2:0]
    input  logic [hms_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // heater_on[0], setpoint[16:1], mode_now[18:17], complete_event[19],
    // fault_event[20], zero pad above
    output logic [hms_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_wen,
    input  logic [hms_pkg::CFG_W-1:0]      cfg_wdata
);
    import hms_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t                    state_reg;
    mode_t                     mode_reg;
    logic [STAMP_W-1:0]        start_stamp_reg;
    logic [STAMP_W-1:0]        run_len_reg;
    logic [STAMP_W-1:0]        elapsed_reg;
    logic [TEMP_W-1:0]         ramp_from_reg;
    logic [TEMP_W-1:0]         ramp_to_reg;
    logic [TEMP_W-1:0]         target_reg;
    logic                      running_reg;
    logic [CFG_W-1:0]          hold_band_reg;
    logic                      done_reg;
    logic                      fault_reg;
    logic                      neg_reg;
    logic [STEP_N-1:0]         mag_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      m_tvalid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;

    // Input fields
    logic [S_TUSER_W-1:0]      in_cmd;
    logic [STAMP_W-1:0]        in_now;
    logic [TEMP_W-1:0]         in_temp;
    logic                      in_fault;
    logic [TEMP_W-1:0]         in_start;
    logic [TEMP_W-1:0]         in_end;
    logic [DUR_W-1:0]          in_dur;
    logic                      in_use;

    logic                      in_xfer;
    logic                      out_free;
    logic [STAMP_W-1:0]        elapsed;
    logic                      ended;
    logic [STAMP_W-1:0]        run_len_next;
    logic signed [TEMP_W:0]    span;
    logic [TEMP_W:0]           span_abs;
    logic signed [TEMP_W:0]    hold_low;
    logic                      heat_start;
    logic                      heat_stop;
    logic [ACC_W-1:0]          acc_mul;
    logic [STAMP_W:0]          div_trial;
    logic [STAMP_W:0]          div_diff;
    logic                      div_ge;
    logic [STAMP_W-1:0]        div_rem;
    logic [STEP_N-1:0]         quot;
    logic [TEMP_W-1:0]         ramp_point;
    logic                      cnt_last;

    assign in_cmd   = s_tuser;
    assign in_now   = s_tdata[31:0];
    assign in_temp  = s_tdata[47:32];
    assign in_fault = s_tdata[48];
    assign in_start = s_tdata[64:49];
    assign in_end   = s_tdata[80:65];
    assign in_dur   = s_tdata[103:81];
    assign in_use   = s_tdata[104];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign cnt_last = (cnt_reg == CNT_W'(STEP_N - 1));

    // Elapsed time and end-of-run test for ticks
    assign elapsed      = in_now - start_stamp_reg;
    assign ended        = (elapsed >= run_len_reg);
    assign run_len_next = STAMP_W'({{(STAMP_W-DUR_W){1'b0}}, in_dur} * MS_PER_S);

    // Ramp span sign and magnitude
    assign span     = $signed({ramp_to_reg[TEMP_W-1], ramp_to_reg})
                    - $signed({ramp_from_reg[TEMP_W-1], ramp_from_reg});
    assign span_abs = span[TEMP_W] ? (TEMP_W+1)'(-span) : span;

    // Hold hysteresis, widened so nothing overflows
    assign hold_low   = $signed({target_reg[TEMP_W-1], target_reg})
                      - $signed({1'b0, {(TEMP_W-CFG_W){1'b0}}, hold_band_reg});
    assign heat_start = $signed({in_temp[TEMP_W-1], in_temp}) < hold_low;
    assign heat_stop  = $signed(in_temp) >= $signed(target_reg);

    // Multiply step: MSB first shift-add of the elapsed time
    assign acc_mul = {acc_reg[ACC_W-2:0], 1'b0}
                   + (mag_reg[STEP_N-1] ? {{STEP_N{1'b0}}, elapsed_reg} : '0);

    // Divide step: restoring, remainder in the upper bits of the accumulator
    assign div_trial = acc_reg[ACC_W-1:STEP_N-1];
    assign div_diff  = div_trial - {1'b0, run_len_reg};
    assign div_ge    = (div_trial >= {1'b0, run_len_reg});
    assign div_rem   = div_ge ? div_diff[STAMP_W-1:0] : div_trial[STAMP_W-1:0];
    assign quot      = {acc_reg[STEP_N-2:0], div_ge};

    // Interpolated setpoint always lies between the end points
    assign ramp_point = neg_reg ? (ramp_from_reg - quot) : (ramp_from_reg + quot);

    // Sequencer, mode state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mode_reg        <= MODE_OFF;
            start_stamp_reg <= '0;
            run_len_reg     <= '0;
            elapsed_reg     <= '0;
            ramp_from_reg   <= '0;
            ramp_to_reg     <= '0;
            target_reg      <= '0;
            running_reg     <= 1'b0;
            hold_band_reg   <= HOLD_BAND_RST;
            done_reg        <= 1'b0;
            fault_reg       <= 1'b0;
            neg_reg         <= 1'b0;
            mag_reg         <= '0;
            acc_reg         <= '0;
            cnt_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
        end
        else
        begin
            // Take register writes at any time
            if (cfg_wen)
            begin
                hold_band_reg <= cfg_wdata;
            end

            // Drop the result once it is taken, unless a new one loads now
            if (m_tready && state_reg != ST_EMIT)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        done_reg  <= 1'b0;
                        fault_reg <= 1'b0;
                        state_reg <= ST_EMIT;
                        case (in_cmd)
                            CMD_TICK:
                            begin
                                if (in_fault)
                                begin
                                    fault_reg   <= 1'b1;
                                    mode_reg    <= MODE_OFF;
                                    running_reg <= 1'b0;
                                end
                                else
                                begin
                                    case (mode_reg)
                                        MODE_RAMP:
                                        begin
                                            if (ended)
                                            begin
                                                target_reg  <= ramp_to_reg;
                                                done_reg    <= 1'b1;
                                                mode_reg    <= MODE_OFF;
                                                running_reg <= 1'b0;
                                            end
                                            else
                                            begin
                                                // Start the serial interpolation
                                                elapsed_reg <= elapsed;
                                                mag_reg     <= span_abs[STEP_N-1:0];
                                                neg_reg     <= span[TEMP_W];
                                                acc_reg     <= '0;
                                                cnt_reg     <= '0;
                                                state_reg   <= ST_MUL;
                                            end
                                        end
                                        MODE_HOLD:
                                        begin
                                            if (!running_reg && heat_start)
                                            begin
                                                running_reg <= 1'b1;
                                            end
                                            else if (running_reg && heat_stop)
                                            begin
                                                running_reg <= 1'b0;
                                            end
                                        end
                                        MODE_TIMER:
                                        begin
                                            running_reg <= !ended;
                                            if (ended)
                                            begin
                                                done_reg <= 1'b1;
                                                mode_reg <= MODE_OFF;
                                            end
                                        end
                                        default:
                                        begin
                                            running_reg <= 1'b0;
                                        end
                                    endcase
                                end
                            end
                            CMD_START_OFF:
                            begin
                                mode_reg    <= MODE_OFF;
                                running_reg <= 1'b0;
                            end
                            CMD_START_RAMP:
                            begin
                                mode_reg        <= MODE_RAMP;
                                ramp_from_reg   <= in_start;
                                ramp_to_reg     <= in_end;
                                run_len_reg     <= run_len_next;
                                start_stamp_reg <= in_now;
                                target_reg      <= in_end;
                                running_reg     <= 1'b1;
                            end
                            CMD_START_HOLD:
                            begin
                                mode_reg    <= MODE_HOLD;
                                target_reg  <= in_end;
                                running_reg <= 1'b1;
                            end
                            CMD_START_TIMER:
                            begin
                                mode_reg        <= MODE_TIMER;
                                run_len_reg     <= run_len_next;
                                start_stamp_reg <= in_now;
                                running_reg     <= 1'b1;
                                if (in_use)
                                begin
                                    target_reg <= in_end;
                                end
                            end
                            default:
                            begin
                                // Unused codes leave the mode and setpoint alone
                            end
                        endcase
                    end
                end
                ST_MUL:
                begin
                    acc_reg <= acc_mul;
                    mag_reg <= {mag_reg[STEP_N-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_last)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    acc_reg <= {div_rem, quot};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_last)
                    begin
                        target_reg  <= ramp_point;
                        running_reg <= 1'b1;
                        state_reg   <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    // Load the output register once it is free
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {3'b000, fault_reg, done_reg, mode_reg,
                                         target_reg, running_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The division remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> acc_reg[ACC_W-1:STEP_N] < run_len_reg)
        else $error("ramp divide remainder out of range");

    // A fault and a completion never come with the same result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[19] && m_tdata[20]))
        else $error("fault and completion reported together");

    // A fault or completion result reports the heater off
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[19] || m_tdata[20]) |->
            m_tdata[18:17] == MODE_OFF && !m_tdata[0])
        else $error("event result not in off mode");

    // The multiply only starts after a transfer taken in ramp mode
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL && $past(state_reg) != ST_MUL |->
            $past(in_xfer) && $past(mode_reg) == MODE_RAMP)
        else $error("interpolation started without a ramp tick");

endmodule
